FILE: src/nrgsp_pkg.sv
// Package: constants, types and helper functions for the NMEA RMC/GSV parser.
`timescale 1ns / 1ps
`default_nettype none
package nrgsp_pkg;

   localparam int MaxLineBytes = 128;

   localparam logic [2:0] ST_BAD_SUM   = 3'd0;
   localparam logic [2:0] ST_UNKNOWN   = 3'd1;
   localparam logic [2:0] ST_RMC_FIX   = 3'd2;
   localparam logic [2:0] ST_RMC_NOFIX = 3'd3;
   localparam logic [2:0] ST_RMC_BAD   = 3'd4;
   localparam logic [2:0] ST_GSV_OK    = 3'd5;
   localparam logic [2:0] ST_GSV_BAD   = 3'd6;
   localparam logic [2:0] ST_TOO_LONG  = 3'd7;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_W     = 8'h57;

   localparam logic [6:0] RMC_FIELDS = 7'd13;

   // per-line parse state
   typedef struct packed {
      logic [7:0]  line_len;
      logic [6:0]  field_num;
      logic [6:0]  char_pos;
      logic [7:0]  xsum;
      logic        after_star;
      logic [7:0]  hex_val;
      logic        hex_bad;
      logic [1:0]  type_bits;
      logic        parse_err;
      logic        fix_err;
      logic [7:0]  sats_acc;
      logic [1:0]  frac_cnt;
      logic        dot_seen;
      logic [31:0] p_time;
      logic [31:0] p_lat;
      logic [31:0] p_lon;
      logic [31:0] p_speed;
      logic [31:0] p_course;
      logic [2:0]  hemi;
   } line_state_type;

   typedef struct packed {
      logic [31:0] utc;
      logic [31:0] lat;
      logic [31:0] lon;
      logic [31:0] speed;
      logic [31:0] course;
      logic [7:0]  sats;
      logic [7:0]  vhist;
   } store_type;

   function automatic logic [7:0] tag_rmc(input logic [2:0] p);
      case (p)
         3'd0: tag_rmc = 8'h24;
         3'd1: tag_rmc = 8'h47;
         3'd2: tag_rmc = 8'h50;
         3'd3: tag_rmc = 8'h52;
         3'd4: tag_rmc = 8'h4D;
         3'd5: tag_rmc = 8'h43;
         default: tag_rmc = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tag_gsv(input logic [2:0] p);
      case (p)
         3'd0: tag_gsv = 8'h24;
         3'd1: tag_gsv = 8'h47;
         3'd2: tag_gsv = 8'h50;
         3'd3: tag_gsv = 8'h47;
         3'd4: tag_gsv = 8'h53;
         3'd5: tag_gsv = 8'h56;
         default: tag_gsv = 8'h00;
      endcase
   endfunction

   function automatic logic [25:0] w_time(input logic [3:0] p);
      case (p)
         4'd0: w_time = 26'd36000000;
         4'd1: w_time = 26'd3600000;
         4'd2: w_time = 26'd600000;
         4'd3: w_time = 26'd60000;
         4'd4: w_time = 26'd10000;
         4'd5: w_time = 26'd1000;
         4'd7: w_time = 26'd100;
         4'd8: w_time = 26'd10;
         4'd9: w_time = 26'd1;
         default: w_time = 26'd0;
      endcase
   endfunction

   function automatic logic [25:0] w_lat(input logic [3:0] p);
      case (p)
         4'd0: w_lat = 26'd6000000;
         4'd1: w_lat = 26'd600000;
         4'd2: w_lat = 26'd100000;
         4'd3: w_lat = 26'd10000;
         4'd5: w_lat = 26'd1000;
         4'd6: w_lat = 26'd100;
         4'd7: w_lat = 26'd10;
         4'd8: w_lat = 26'd1;
         default: w_lat = 26'd0;
      endcase
   endfunction

   function automatic logic [25:0] w_lon(input logic [3:0] p);
      case (p)
         4'd0: w_lon = 26'd60000000;
         4'd1: w_lon = 26'd6000000;
         4'd2: w_lon = 26'd600000;
         4'd3: w_lon = 26'd100000;
         4'd4: w_lon = 26'd10000;
         4'd6: w_lon = 26'd1000;
         4'd7: w_lon = 26'd100;
         4'd8: w_lon = 26'd10;
         4'd9: w_lon = 26'd1;
         default: w_lon = 26'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: src/nrgsp_line.sv
// Per-character line parser: checksum, type match, field accumulators.
`timescale 1ns / 1ps
`default_nettype none
module nrgsp_line import nrgsp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,     // a non-LF, non-CR character is taken
   input  wire logic           clear,    // LF taken: restart line
   input  wire logic [7:0]     c,
   output line_state_type      st
);

   line_state_type st_ff, st_in;

   assign st = st_ff;

   function automatic logic is_dig(input logic [7:0] x);
      is_dig = (x >= 8'h30) && (x <= 8'h39);
   endfunction

   function automatic line_state_type reset_line();
      line_state_type r;
      r = '0;
      r.type_bits = 2'b11;
      reset_line = r;
   endfunction

   logic [3:0]  d;
   logic [7:0]  up;
   logic [3:0]  hx;
   logic        hx_ok;
   logic [3:0]  p4;
   logic [31:0] fx_add;

   always_comb begin
      d  = 4'(c - CH_ZERO);
      up = ((c >= 8'h61) && (c <= 8'h7A)) ? 8'(c - 8'd32) : c;
      hx_ok = 1'b1;
      hx = 4'd0;
      if (is_dig(c)) hx = d;
      else if (c >= 8'h41 && c <= 8'h46) hx = 4'(c - 8'h37);
      else if (c >= 8'h61 && c <= 8'h66) hx = 4'(c - 8'h57);
      else hx_ok = 1'b0;
      p4 = (st_ff.char_pos < 7'd10) ? st_ff.char_pos[3:0] : 4'd15;
      fx_add = '0;
      case (st_ff.field_num)
         7'd1: fx_add = 32'(d) * 32'(w_time(p4));
         7'd3: fx_add = 32'(d) * 32'(w_lat(p4));
         7'd5: fx_add = 32'(d) * 32'(w_lon(p4));
         default: fx_add = '0;
      endcase
   end

   always_comb begin
      logic dot_pos;
      logic bad_fixed;
      logic [31:0] dv;
      logic [31:0] acc;
      logic first;
      st_in = st_ff;
      dot_pos = 1'b0;
      bad_fixed = 1'b0;
      dv = 32'(d);
      acc = 32'd0;
      first = (st_ff.line_len == 8'd0);
      if (clear) begin
         st_in = reset_line();
      end else if (step) begin
         if (st_ff.after_star) begin
            if (!hx_ok) st_in.hex_bad = 1'b1;
            else st_in.hex_val = {st_ff.hex_val[3:0], hx};
         end else if (!first && c == CH_STAR || !first && c == CH_COMMA) begin
            if (c == CH_STAR) st_in.after_star = 1'b1;
            else st_in.xsum = st_ff.xsum ^ c;
            // field end
            if (st_ff.field_num == 7'd0) begin
               if (st_ff.char_pos != 7'd6) st_in.type_bits = 2'b00;
            end else if (st_ff.type_bits[0]) begin
               if (st_ff.field_num == 7'd1 && st_ff.char_pos < 7'd7) st_in.parse_err = 1'b1;
               if (st_ff.field_num == 7'd3 && st_ff.char_pos < 7'd5) st_in.fix_err = 1'b1;
               if (st_ff.field_num == 7'd5 && st_ff.char_pos < 7'd6) st_in.fix_err = 1'b1;
               if ((st_ff.field_num == 7'd7 || st_ff.field_num == 7'd8) && !st_ff.dot_seen)
                  st_in.fix_err = 1'b1;
            end
            st_in.dot_seen = 1'b0;
            st_in.frac_cnt = 2'd0;
            st_in.char_pos = 7'd0;
            if (st_ff.field_num < 7'd127) st_in.field_num = 7'(st_ff.field_num + 7'd1);
         end else begin
            if (!first) st_in.xsum = st_ff.xsum ^ c;
            // field character
            if (st_ff.field_num == 7'd0) begin
               if (st_ff.char_pos >= 7'd6 || up != tag_rmc(st_ff.char_pos[2:0]))
                  st_in.type_bits[0] = 1'b0;
               if (st_ff.char_pos >= 7'd6 || up != tag_gsv(st_ff.char_pos[2:0]))
                  st_in.type_bits[1] = 1'b0;
            end else if (st_ff.type_bits[0]) begin
               case (st_ff.field_num)
                  7'd1, 7'd3, 7'd5: begin
                     dot_pos = (st_ff.field_num == 7'd1) ? (st_ff.char_pos == 7'd6) :
                               (st_ff.field_num == 7'd3) ? (st_ff.char_pos == 7'd4) :
                                                           (st_ff.char_pos == 7'd5);
                     bad_fixed = dot_pos ? (c != CH_DOT) : !is_dig(c);
                     if (bad_fixed) begin
                        if (st_ff.field_num == 7'd1) st_in.parse_err = 1'b1;
                        else st_in.fix_err = 1'b1;
                     end else if (!dot_pos) begin
                        case (st_ff.field_num)
                           7'd1: st_in.p_time = st_ff.p_time + fx_add;
                           7'd3: st_in.p_lat  = st_ff.p_lat + fx_add;
                           default: st_in.p_lon = st_ff.p_lon + fx_add;
                        endcase
                     end
                  end
                  7'd2: if (st_ff.char_pos == 7'd0 && c == CH_V) st_in.hemi[2] = 1'b1;
                  7'd4: if (st_ff.char_pos == 7'd0 && c == CH_S) st_in.hemi[0] = 1'b1;
                  7'd6: if (st_ff.char_pos == 7'd0 && c == CH_W) st_in.hemi[1] = 1'b1;
                  7'd7, 7'd8: begin
                     acc = (st_ff.field_num == 7'd7) ? st_ff.p_speed : st_ff.p_course;
                     if (c == CH_DOT && !st_ff.dot_seen && st_ff.char_pos != 7'd0) begin
                        st_in.dot_seen = 1'b1;
                     end else if (!is_dig(c)) begin
                        st_in.fix_err = 1'b1;
                     end else if (!st_ff.dot_seen) begin
                        acc = (acc << 3) + (acc << 1) + dv * 32'd100;
                     end else if (st_ff.frac_cnt < 2'd2) begin
                        acc = acc + ((st_ff.frac_cnt == 2'd0) ? dv * 32'd10 : dv);
                        st_in.frac_cnt = 2'(st_ff.frac_cnt + 2'd1);
                     end
                     if (st_ff.field_num == 7'd7) st_in.p_speed = acc;
                     else st_in.p_course = acc;
                  end
                  default: ;
               endcase
            end else if (st_ff.type_bits[1] && st_ff.field_num == 7'd3) begin
               if (is_dig(c))
                  st_in.sats_acc = 8'((st_ff.sats_acc << 3) + (st_ff.sats_acc << 1) + 8'(d));
               else st_in.parse_err = 1'b1;
            end
            if (st_ff.char_pos < 7'd127) st_in.char_pos = 7'(st_ff.char_pos + 7'd1);
         end
         if (st_ff.line_len < 8'd255) st_in.line_len = 8'(st_ff.line_len + 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= reset_line();
      else st_ff <= st_in;
   end

endmodule
`default_nettype wire

FILE: src/nrgsp_commit.sv
// Line-end decision: status, commit of stored values, validity history.
`timescale 1ns / 1ps
`default_nettype none
module nrgsp_commit import nrgsp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       line_end,
   input  line_state_type  st,
   output logic [2:0]      status,
   output store_type       store_next
);

   store_type sto_ff;

   always_comb begin
      store_next = sto_ff;
      status = ST_BAD_SUM;
      if (st.line_len > 8'(MaxLineBytes - 1)) begin
         status = ST_TOO_LONG;
      end else if (!st.after_star || st.hex_bad || st.xsum != st.hex_val) begin
         status = ST_BAD_SUM;
      end else if (st.type_bits == 2'b00) begin
         status = ST_UNKNOWN;
      end else if (st.type_bits[0]) begin
         if (st.field_num != RMC_FIELDS) begin
            status = ST_RMC_BAD;
         end else begin
            store_next.vhist = {sto_ff.vhist[6:0], 1'b0};
            if (st.parse_err) begin
               status = ST_RMC_BAD;
            end else if (st.hemi[2]) begin
               store_next.utc = st.p_time;
               status = ST_RMC_NOFIX;
            end else if (st.fix_err) begin
               status = ST_RMC_BAD;
            end else begin
               store_next.utc = st.p_time;
               store_next.lat = st.hemi[0] ? 32'(-st.p_lat) : st.p_lat;
               store_next.lon = st.hemi[1] ? 32'(-st.p_lon) : st.p_lon;
               store_next.speed = st.p_speed;
               store_next.course = st.p_course;
               store_next.vhist = {sto_ff.vhist[6:0], 1'b1};
               status = ST_RMC_FIX;
            end
         end
      end else if (st.field_num <= 7'd4 || st.parse_err) begin
         status = ST_GSV_BAD;
      end else begin
         store_next.sats = st.sats_acc;
         status = ST_GSV_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sto_ff <= '0;
      else if (line_end) sto_ff <= store_next;
   end

endmodule
`default_nettype wire

FILE: src/nmea_rmc_gsv_sentence_parser.sv
// Top level of the NMEA RMC/GSV sentence parser.
//  channel | dir | contents
//  req_    | in  | one ASCII character per transfer
//  rsp_    | out | status and stored values, one transfer per LF
// One byte per cycle unless stalled; a result shows the cycle after its LF.
// Parse state lives in one register set updated by short logic per byte.
// A single output register holds a result; the input stalls while that
// register is full and rsp_tready is low, whatever the incoming byte.
// Reset clears all parse and stored state.
`timescale 1ns / 1ps
`default_nettype none
module nmea_rmc_gsv_sentence_parser import nrgsp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // line_status, utc_ms, latitude, longitude, ground_speed, ground_course,
   // sats_in_view, valid_history
   output logic [151:0]      rsp_tdata
);

   line_state_type st;
   store_type      nxt;
   logic [2:0]     status;
   logic           take, is_lf, is_cr;
   logic           rv_ff;
   logic [151:0]   rd_ff;

   assign req_tready = !rv_ff || rsp_tready;
   assign take  = req_tvalid && req_tready;
   assign is_lf = req_tdata == CH_LF;
   assign is_cr = req_tdata == CH_CR;

   nrgsp_line u_line (
      .clock(clock), .reset(reset),
      .step(take && !is_lf && !is_cr), .clear(take && is_lf),
      .c(req_tdata), .st(st)
   );

   nrgsp_commit u_commit (
      .clock(clock), .reset(reset), .line_end(take && is_lf),
      .st(st), .status(status), .store_next(nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (take && is_lf) rv_ff <= 1'b1;
      else if (rsp_tready) rv_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take && is_lf)
         rd_ff <= {5'b00000, nxt.vhist, nxt.sats, nxt.course[15:0], nxt.speed[15:0],
                   nxt.lon, nxt.lat, nxt.utc, status};
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Testbench for the NMEA RMC/GSV sentence parser: directed and random sentences, scoreboarded.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import nrgsp_pkg::*;

   typedef struct packed {
      logic [7:0]  vhist;
      logic [7:0]  sats;
      logic [15:0] course;
      logic [15:0] speed;
      logic [31:0] lon;
      logic [31:0] lat;
      logic [31:0] utc;
      logic [2:0]  status;
   } line_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;    // rx_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;          // line_status, utc_ms, latitude, longitude, ground_speed,
                                     // ground_course, sats_in_view, valid_history

   nmea_rmc_gsv_sentence_parser uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   line_result_type line_results_q[$];
   int mismatches = 0;
   bit no_idle = 1'b0;

   // predictor state
   logic [7:0]  m_len;
   logic [6:0]  m_field, m_pos;
   logic [7:0]  m_xor, m_hex;
   logic        m_star, m_hex_bad, m_perr, m_ferr, m_dot;
   logic [1:0]  m_type;
   logic [7:0]  m_sats_acc;
   logic [1:0]  m_frac;
   logic [31:0] m_pend[5];
   logic [2:0]  m_hemi;
   logic [31:0] m_store[5];
   logic [7:0]  m_sats, m_vhist;

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int weight_of(int f, int p);
      int wt[10], wa[10], wo[10];
      wt = '{36000000, 3600000, 600000, 60000, 10000, 1000, 0, 100, 10, 1};
      wa = '{6000000, 600000, 100000, 10000, 0, 1000, 100, 10, 1, 0};
      wo = '{60000000, 6000000, 600000, 100000, 10000, 0, 1000, 100, 10, 1};
      if (p > 9) return 0;
      return f == 1 ? wt[p] : f == 3 ? wa[p] : wo[p];
   endfunction

   task automatic clear_line_state();
      m_len = 0; m_field = 0; m_pos = 0; m_xor = 0; m_hex = 0; m_star = 0;
      m_hex_bad = 0; m_type = 2'b11; m_perr = 0; m_ferr = 0; m_dot = 0;
      m_sats_acc = 0; m_frac = 0; m_hemi = 0;
      foreach (m_pend[i]) m_pend[i] = 0;
   endtask

   task automatic fixed_digit(logic [7:0] c, int p, int f, int dotp, int n, ref logic err);
      if (p == dotp) begin
         if (c != ".") err = 1;
      end else if (!is_dig(c)) begin
         err = 1;
      end else if (p < n) begin
         m_pend[f == 1 ? 0 : f == 3 ? 1 : 2] += (c - "0") * weight_of(f, p);
      end
   endtask

   task automatic decimal_digit(logic [7:0] c, int p, int idx);
      if (c == "." && !m_dot && p > 0) m_dot = 1;
      else if (!is_dig(c)) m_ferr = 1;
      else if (!m_dot) m_pend[idx] = m_pend[idx] * 10 + (c - "0") * 100;
      else if (m_frac < 2) begin
         m_pend[idx] += (c - "0") * (m_frac == 0 ? 10 : 1);
         m_frac++;
      end
   endtask

   task automatic field_byte(logic [7:0] c);
      logic [7:0] u;
      int p, f;
      p = m_pos; f = m_field;
      if (f == 0) begin
         u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
         if (p >= 6 || u != 8'("$GPRMC" >> (8 * (5 - p)))) m_type &= 2'b10;
         if (p >= 6 || u != 8'("$GPGSV" >> (8 * (5 - p)))) m_type &= 2'b01;
      end else if (m_type[0]) begin
         case (f)
            1: fixed_digit(c, p, 1, 6, 10, m_perr);
            2: if (p == 0 && c == CH_V) m_hemi[2] = 1;
            3: fixed_digit(c, p, 3, 4, 9, m_ferr);
            4: if (p == 0 && c == CH_S) m_hemi[0] = 1;
            5: fixed_digit(c, p, 5, 5, 10, m_ferr);
            6: if (p == 0 && c == CH_W) m_hemi[1] = 1;
            7: decimal_digit(c, p, 3);
            8: decimal_digit(c, p, 4);
            default: ;
         endcase
      end else if (m_type[1] && f == 3) begin
         if (is_dig(c)) m_sats_acc = m_sats_acc * 8'd10 + (c - "0");
         else m_perr = 1;
      end
      if (m_pos < 127) m_pos++;
   endtask

   task automatic field_close();
      if (m_field == 0) begin
         if (m_pos != 6) m_type = 0;
      end else if (m_type[0]) begin
         if (m_field == 1 && m_pos < 7) m_perr = 1;
         if (m_field == 3 && m_pos < 5) m_ferr = 1;
         if (m_field == 5 && m_pos < 6) m_ferr = 1;
         if ((m_field == 7 || m_field == 8) && !m_dot) m_ferr = 1;
      end
      m_dot = 0; m_frac = 0; m_pos = 0;
      if (m_field < 127) m_field++;
   endtask

   function automatic logic [2:0] close_line();
      if (m_len > MaxLineBytes - 1) return ST_TOO_LONG;
      if (!m_star || m_hex_bad || m_xor != m_hex) return ST_BAD_SUM;
      if (m_type == 0) return ST_UNKNOWN;
      if (m_type[0]) begin
         if (m_field != RMC_FIELDS) return ST_RMC_BAD;
         m_vhist = m_vhist << 1;
         if (m_perr) return ST_RMC_BAD;
         if (m_hemi[2]) begin
            m_store[0] = m_pend[0];
            return ST_RMC_NOFIX;
         end
         if (m_ferr) return ST_RMC_BAD;
         m_store[0] = m_pend[0];
         m_store[1] = m_hemi[0] ? -m_pend[1] : m_pend[1];
         m_store[2] = m_hemi[1] ? -m_pend[2] : m_pend[2];
         m_store[3] = m_pend[3];
         m_store[4] = m_pend[4];
         m_vhist[0] = 1;
         return ST_RMC_FIX;
      end
      if (m_field <= 4 || m_perr) return ST_GSV_BAD;
      m_sats = m_sats_acc;
      return ST_GSV_OK;
   endfunction

   task automatic predict_byte(logic [7:0] c);
      line_result_type r;
      int v;
      if (c == CH_CR) return;
      if (c == CH_LF) begin
         r.status = close_line();
         r.utc = m_store[0]; r.lat = m_store[1]; r.lon = m_store[2];
         r.speed = m_store[3][15:0]; r.course = m_store[4][15:0];
         r.sats = m_sats; r.vhist = m_vhist;
         line_results_q.push_back(r);
         clear_line_state();
         return;
      end
      if (m_star) begin
         if (is_dig(c)) v = c - "0";
         else if (c >= "A" && c <= "F") v = c - "A" + 10;
         else if (c >= "a" && c <= "f") v = c - "a" + 10;
         else v = -1;
         if (v < 0) m_hex_bad = 1;
         else m_hex = {m_hex[3:0], 4'(v)};
      end else if (m_len == 0) field_byte(c);
      else if (c == CH_STAR) begin
         m_star = 1;
         field_close();
      end else begin
         m_xor ^= c;
         if (c == CH_COMMA) field_close();
         else field_byte(c);
      end
      if (m_len < 255) m_len++;
   endtask

   // one character transfer; tvalid stays high between back-to-back transfers
   task automatic send_byte(logic [7:0] c);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      predict_byte(c);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   function automatic string hex2(logic [7:0] v, bit lower);
      return lower ? $sformatf("%02x", v) : $sformatf("%02X", v);
   endfunction

   // appends *hh CRLF with a correct sum to a body that starts with $
   task automatic send_sentence(string body, bit lower = 0);
      logic [7:0] x;
      x = 0;
      foreach (body[i]) if (i > 0) x ^= body[i];
      send_text({body, "*", hex2(x, lower), "\r\n"});
   endtask

   always @(posedge clock) begin
      line_result_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[146:0];
         if (line_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            exp = line_results_q.pop_front();
            if (got !== exp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d utc=%0d lat=%0d lon=%0d spd=%0d crs=%0d sat=%0d vh=%h | got st=%0d utc=%0d lat=%0d lon=%0d spd=%0d crs=%0d sat=%0d vh=%h",
                     exp.status, exp.utc, $signed(exp.lat), $signed(exp.lon), $signed(exp.speed),
                     $signed(exp.course), exp.sats, exp.vhist, got.status, got.utc,
                     $signed(got.lat), $signed(got.lon), $signed(got.speed), $signed(got.course),
                     got.sats, got.vhist);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= no_idle || $urandom_range(99) >= 9;

   function automatic string digits(int n);
      string s = "";
      repeat (n) s = {s, string'(8'("0" + $urandom_range(9)))};
      return s;
   endfunction

   function automatic string rand_rmc();
      string s;
      s = {$urandom_range(1) ? "$GPRMC" : "$gprmc", ",", digits(6), ".", digits($urandom_range(4))};
      s = {s, ",", $urandom_range(3) == 0 ? "V" : "A"};
      s = {s, ",", digits(4), ".", digits($urandom_range(5)), ",", $urandom_range(1) ? "S" : "N"};
      s = {s, ",", digits(5), ".", digits($urandom_range(5)), ",", $urandom_range(1) ? "W" : "E"};
      s = {s, ",", digits($urandom_range(1, 5)), ".", digits($urandom_range(3))};
      s = {s, ",", digits($urandom_range(1, 5)), ".", digits($urandom_range(3)), ",",
           digits(6), ",,,A"};
      return s;
   endfunction

   function automatic string rand_gsv();
      return {$urandom_range(1) ? "$GPGSV" : "$GpGsV", ",", digits(1), ",", digits(1), ",",
              digits($urandom_range(4)), ",", digits(2)};
   endfunction

   // corrupts one character of a sentence
   function automatic string mangle(string s);
      int k;
      k = $urandom_range(s.len() - 1);
      s[k] = 8'($urandom_range(255));
      if (s[k] == CH_LF || s[k] == CH_CR) s[k] = ",";
      return s;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (line_results_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_sentence("$GPRMC,235959.999,A,8959.9999,S,17959.9999,W,655.35,359.99,311299,,,A");
      send_sentence("$gprmc,000000.,A,0000.,N,00000.,E,0.,0.,010100,,,A", 1);
      send_sentence("$GPRMC,123519.5,V,4807.038,N,01131.000,E,022.4,084.4,230394,,,A");
      send_sentence("$GPRMC,12a519.5,A,4807.038,N,01131.000,E,022.4,084.4,230394,,,A");
      send_sentence("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,,,A");
      send_sentence("$GPRMC,123519.12345,A,4807.0381234,N,01131.000,E,9999.999,.5,230394,,,A");
      send_sentence("$GPRMC,1,A,2");
      send_sentence("$GPGSV,3,1,11,03,03,111,00");
      send_sentence("$GPGSV,3,1,999");
      send_sentence("$GPGSV,3,1,");
      send_sentence("$GPGSV,3,1,1x");
      send_sentence("$GPGSV,1,1");
      send_sentence("$GPXYZ,1,2");
      send_sentence("$GPRMCX,1");
      send_text("$GPGSV,1,1,05*00\r\n");
      send_text("$GPGSV,1,1,05\n");
      send_text("$GPGSV,1,1,05*zz\n");
      send_text("$GPGSV,1,1,05*0000000072\n");
      send_text("*,*\n");
      send_text("\n");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_LF);
      send_text({"$GPGSV,", digits(140), "\n"});
   endtask

   task automatic test_pause();
      send_sentence("$GPGSV,2,2,42");
      wait_drained();
      send_sentence(rand_rmc());
   endtask

   task automatic test_random(int n_items);
      string s;
      int sent, k;
      sent = 0;
      while (sent < n_items) begin
         k = $urandom_range(99);
         if (k < 45) s = rand_rmc();
         else if (k < 70) s = rand_gsv();
         else if (k < 85) s = mangle($urandom_range(1) ? rand_rmc() : rand_gsv());
         else s = "";
         if (k >= 85) begin
            repeat ($urandom_range(1, 40)) s = {s, string'(8'($urandom_range(255)))};
            send_text({s, "\n"});
         end else if ($urandom_range(19) == 0) send_text({s, "*", hex2(8'($urandom), 0), "\n"});
         else send_sentence(s, $urandom_range(1));
         sent += s.len() + 4;
      end
   endtask

   initial begin
      clear_line_state();
      foreach (m_store[i]) m_store[i] = 0;
      m_sats = 0; m_vhist = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_pause();
      test_random(200);
      no_idle = 1'b1;
      test_random(200);
      no_idle = 1'b0;
      test_random(200);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && line_results_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
src/nrgsp_pkg.sv
src/nrgsp_line.sv
src/nrgsp_commit.sv
src/nmea_rmc_gsv_sentence_parser.sv
verif/tb.sv
